// ----- rtl/core/rdcc_pkg.sv -----
// Shared constants, codes and types of the rectangle distinct-color counter.
// Depends on nothing; every other file of the block except rdcc_ram imports it.
package rdcc_pkg;

    localparam int MAX_POINTS     = 1024;
    localparam int COLOR_COUNT    = 256;
    localparam int COORD_BITS     = 16;
    localparam int COLOR_BITS     = 8;
    localparam int MODE_BITS      = 2;
    localparam int OUT_BITS       = 9;
    localparam int ADDR_BITS      = $clog2(MAX_POINTS);
    localparam int CNT_BITS       = $clog2(MAX_POINTS + 1);
    localparam int COLOR_IDX_BITS = $clog2(COLOR_COUNT);

    localparam logic [MODE_BITS-1:0] MODE_CLEAR = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_LOAD  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_QUERY = 2'd2;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord                x;
        t_coord                y;
        logic [COLOR_BITS-1:0] color;
    } t_point;

    typedef struct packed {
        t_coord x_low;
        t_coord x_high;
        t_coord y_low;
        t_coord y_high;
    } t_rect;

    // Control from the sequencer to the tally unit.
    typedef struct packed {
        logic clear;
        logic hit_vld;
    } t_tally_ctl;

endpackage

// ----- rtl/core/rdcc_if.sv -----
// Valid/ready channel interfaces for the input and result beats.
// Depends on rdcc_pkg for field widths.
interface rdcc_in_if;
    import rdcc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [MODE_BITS-1:0]  mode;
    t_coord                point_x;
    t_coord                point_y;
    logic [COLOR_BITS-1:0] point_color;
    t_coord                x_low;
    t_coord                x_high;
    t_coord                y_low;
    t_coord                y_high;

    modport source (output valid, mode, point_x, point_y, point_color,
                    x_low, x_high, y_low, y_high, input ready);
    modport sink   (input valid, mode, point_x, point_y, point_color,
                    x_low, x_high, y_low, y_high, output ready);
endinterface

interface rdcc_out_if;
    import rdcc_pkg::*;

    logic                valid;
    logic                ready;
    logic [OUT_BITS-1:0] distinct_colors;

    modport source (output valid, distinct_colors, input ready);
    modport sink   (input valid, distinct_colors, output ready);
endinterface

// ----- rtl/core/rect_distinct_color_count.sv -----
// Top level of the rectangle distinct-color counter.
// Depends on rdcc_pkg, rdcc_if, rdcc_ram and rdcc_tally.
//
// The block keeps up to MAX_POINTS colored points in a RAM. A clear beat
// empties the store, a load beat appends one point (loads into a full store
// are dropped), and a query beat carries a rectangle with inclusive bounds
// and returns one result beat with the number of distinct colors among the
// stored points inside it. Clear, load and unused-mode beats give no result.
// A query takes the beat and clears the color map, reads the stored points in
// turn, since the point RAM has a single read port and the compare unit tests
// one point a cycle, lets the last registered read drain, and moves the count
// into the output register. Input is not ready during a query. The output
// register frees the input side: new beats are taken while a result waits,
// and a second query only waits in its final cycle if the previous result
// has not been taken.
module rect_distinct_color_count (
    input  logic  i_clk,
    input  logic  i_rst_n,
    rdcc_in_if.sink    i_in,
    rdcc_out_if.source o_out
);
    import rdcc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic [CNT_BITS-1:0] r_stored;
    logic [CNT_BITS-1:0] n_stored;
    logic [CNT_BITS-1:0] r_idx;
    logic [CNT_BITS-1:0] n_idx;
    logic                r_rd_vld;
    t_rect               r_rect;
    t_rect               n_rect;
    logic                r_out_vld;
    logic                n_out_vld;
    logic [OUT_BITS-1:0] r_out_data;
    logic [OUT_BITS-1:0] n_out_data;

    logic                accept;
    logic                not_full;
    logic                ram_we;
    logic                ram_re;
    t_point              wr_point;
    logic [$bits(t_point)-1:0] rd_raw;
    t_point              rd_point;
    t_tally_ctl          tally_ctl;
    logic [OUT_BITS-1:0] tally_count;

    assign i_in.ready = (r_state == ST_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign not_full   = (r_stored < CNT_BITS'(MAX_POINTS));

    // Point store: written by load beats, read one entry a cycle while scanning.
    assign ram_we   = accept && (i_in.mode == MODE_LOAD) && not_full;
    assign ram_re   = (r_state == ST_SCAN) && (r_idx < r_stored);
    assign wr_point = '{x: i_in.point_x, y: i_in.point_y, color: i_in.point_color};

    rdcc_ram #(
        .WIDTH ($bits(t_point)),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_stored[ADDR_BITS-1:0]),
        .i_wdata (wr_point),
        .i_re    (ram_re),
        .i_raddr (r_idx[ADDR_BITS-1:0]),
        .o_rdata (rd_raw)
    );

    assign rd_point = t_point'(rd_raw);

    // The color map is cleared when the query beat is taken; read data that
    // arrives in the cycle after each issued address goes through the compare unit.
    assign tally_ctl.clear   = accept && (i_in.mode == MODE_QUERY);
    assign tally_ctl.hit_vld = r_rd_vld;

    rdcc_tally u_tally (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (tally_ctl),
        .i_point (rd_point),
        .i_rect  (r_rect),
        .o_count (tally_count)
    );

    always_comb begin
        n_state    = r_state;
        n_stored   = r_stored;
        n_idx      = r_idx;
        n_rect     = r_rect;
        n_out_vld  = r_out_vld;
        n_out_data = r_out_data;

        if (r_out_vld && o_out.ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    priority if (i_in.mode == MODE_CLEAR) begin
                        n_stored = '0;
                    end else if (i_in.mode == MODE_LOAD) begin
                        if (not_full) begin
                            n_stored = r_stored + 1'b1;
                        end
                    end else if (i_in.mode == MODE_QUERY) begin
                        n_rect  = '{x_low: i_in.x_low, x_high: i_in.x_high,
                                    y_low: i_in.y_low, y_high: i_in.y_high};
                        n_idx   = '0;
                        n_state = ST_SCAN;
                    end else begin
                        // The unused mode is taken and does nothing.
                        n_stored = r_stored;
                    end
                end
            end
            ST_SCAN: begin
                if (ram_re) begin
                    n_idx = r_idx + 1'b1;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // The last point was counted in the previous cycle.
                if (!r_out_vld || o_out.ready) begin
                    n_out_vld  = 1'b1;
                    n_out_data = tally_count;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_stored  <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_stored  <= n_stored;
            r_idx     <= n_idx;
            r_rd_vld  <= ram_re;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rect     <= n_rect;
        r_out_data <= n_out_data;
    end

    assign o_out.valid           = r_out_vld;
    assign o_out.distinct_colors = r_out_data;
endmodule

// ----- rtl/core/rdcc_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module rdcc_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/core/rdcc_tally.sv -----
// Shared compare unit and color-seen map: tests one point a cycle against the
// rectangle and counts first sightings of each color. Depends on rdcc_pkg.
module rdcc_tally (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rdcc_pkg::t_tally_ctl           i_ctl,
    input  rdcc_pkg::t_point               i_point,
    input  rdcc_pkg::t_rect                i_rect,
    output logic [rdcc_pkg::OUT_BITS-1:0]  o_count
);
    import rdcc_pkg::*;

    logic [COLOR_COUNT-1:0]    r_seen;
    logic [COLOR_COUNT-1:0]    n_seen;
    logic [OUT_BITS-1:0]       r_count;
    logic [OUT_BITS-1:0]       n_count;
    logic                      in_rect;
    logic                      in_range;
    logic                      hit;
    logic [COLOR_IDX_BITS-1:0] idx;

    // Signed compares on both axes; an inverted bound simply never matches.
    assign in_rect = (i_point.x >= i_rect.x_low) && (i_point.x <= i_rect.x_high) &&
                     (i_point.y >= i_rect.y_low) && (i_point.y <= i_rect.y_high);
    assign in_range = (32'(i_point.color) < COLOR_COUNT);
    assign idx      = COLOR_IDX_BITS'(i_point.color);
    assign hit      = i_ctl.hit_vld && in_rect && in_range && !r_seen[idx];

    always_comb begin
        n_seen  = r_seen;
        n_count = r_count;
        if (i_ctl.clear) begin
            n_seen  = '0;
            n_count = '0;
        end else if (hit) begin
            n_seen[idx] = 1'b1;
            if (r_count != '1) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= '0;
            r_count <= '0;
        end else begin
            r_seen  <= n_seen;
            r_count <= n_count;
        end
    end

    assign o_count = r_count;
endmodule
